[hdl/tkfs_pkg.sv]
package tkfs_pkg;

  // Field widths of one word on either stream
  localparam int FREQ_W  = 32;
  localparam int WORD_W  = 64;
  localparam int K_W     = 5;
  localparam int ENTRY_W = FREQ_W + WORD_W;
  localparam int TDATA_W = 96;

  // Microprogram step address
  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE     = 4'd0;
  localparam step_t ST_CHK_FULL = 4'd1;
  localparam step_t ST_FULL_CMP = 4'd2;
  localparam step_t ST_SCAN_RD  = 4'd3;
  localparam step_t ST_SCAN_CMP = 4'd4;
  localparam step_t ST_WR_NEW   = 4'd5;
  localparam step_t ST_CHK_LAST = 4'd6;
  localparam step_t ST_EMIT_RD  = 4'd7;
  localparam step_t ST_EMIT     = 4'd8;

  // Read address source for the kept-item memory
  typedef enum logic [1:0] {
    RD_POS,
    RD_POSM1,
    RD_KM1
  } rd_sel_e;

  // Datapath action of one step
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_FULL_CMP,
    ACT_SHIFT,
    ACT_WR_NEW,
    ACT_LAST,
    ACT_EMIT_CHK,
    ACT_EMIT
  } act_e;

  // Jump condition
  typedef enum logic [3:0] {
    C_NEVER,
    C_NO_IN,
    C_NOT_FULL,
    C_NO_RANK,
    C_POS_ZERO,
    C_RANK,
    C_NOT_LAST,
    C_EMIT_END,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    rd_sel_e rd_sel;
    act_e    act;
    cond_e   cond;
    step_t   jmp;
    step_t   nxt;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic not_full;
    logic rank;
    logic pos_zero;
    logic is_last;
    logic emit_end;
    logic out_busy;
  } status_t;

  // Control store: insertion scan, then best-first emission on the last word
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    unique case (s)
      ST_IDLE:     c = '{RD_POS,   ACT_ACCEPT,   C_NO_IN,    ST_IDLE,     ST_CHK_FULL};
      ST_CHK_FULL: c = '{RD_KM1,   ACT_NONE,     C_NOT_FULL, ST_SCAN_RD,  ST_FULL_CMP};
      ST_FULL_CMP: c = '{RD_POS,   ACT_FULL_CMP, C_NO_RANK,  ST_CHK_LAST, ST_SCAN_RD};
      ST_SCAN_RD:  c = '{RD_POSM1, ACT_NONE,     C_POS_ZERO, ST_WR_NEW,   ST_SCAN_CMP};
      ST_SCAN_CMP: c = '{RD_POS,   ACT_SHIFT,    C_RANK,     ST_SCAN_RD,  ST_WR_NEW};
      ST_WR_NEW:   c = '{RD_POS,   ACT_WR_NEW,   C_NEVER,    ST_IDLE,     ST_CHK_LAST};
      ST_CHK_LAST: c = '{RD_POS,   ACT_LAST,     C_NOT_LAST, ST_IDLE,     ST_EMIT_RD};
      ST_EMIT_RD:  c = '{RD_POS,   ACT_EMIT_CHK, C_EMIT_END, ST_IDLE,     ST_EMIT};
      ST_EMIT:     c = '{RD_POS,   ACT_EMIT,     C_OUT_BUSY, ST_EMIT,     ST_EMIT_RD};
      default:     c = '{RD_POS,   ACT_NONE,     C_NEVER,    ST_IDLE,     ST_IDLE};
    endcase
    return c;
  endfunction

endpackage

[hdl/top_k_frequency_select_top.sv]
// Insertion: a full list that rejects the word stops after one compare with the weakest entry;
// otherwise a read/compare loop over the store shifts each weaker kept entry down one slot.
// A word flagged last then emits the list best first, holding while the output is stalled;
// the next input word is taken while the final result still waits in the output register.
// Reset clears the step counter, fill count and output valid; k_in_use resets to 16.
module top_k_frequency_select_top #(
  parameter int MAX_KEEP = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tkfs_pkg::K_W-1:0]      cfg_data_i,     // k_in_use
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tkfs_pkg::TDATA_W-1:0]  s_axis_tdata,   // freq[31:0], word_key[95:32]
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tkfs_pkg::TDATA_W-1:0]  m_axis_tdata,   // out_freq[31:0], out_word_key[95:32]
  output logic                          m_axis_tlast
);

  tkfs_pkg::ctrl_t   ctrl;
  tkfs_pkg::status_t status;

  // The k register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  tkfs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  tkfs_dp #(
    .MAX_KEEP (MAX_KEEP)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[hdl/tkfs_ram.sv]
module tkfs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tkfs_seq.sv]
module tkfs_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tkfs_pkg::status_t status_i,
  output tkfs_pkg::ctrl_t   ctrl_o
);

  tkfs_pkg::step_t pc_q, pc_d;
  tkfs_pkg::ctrl_t ctrl;
  logic            taken;

  // Control word fetch
  assign ctrl   = tkfs_pkg::ucode(pc_q);
  assign ctrl_o = ctrl;

  // Condition select
  always_comb begin
    unique case (ctrl.cond)
      tkfs_pkg::C_NEVER:    taken = 1'b0;
      tkfs_pkg::C_NO_IN:    taken = !status_i.in_valid;
      tkfs_pkg::C_NOT_FULL: taken = status_i.not_full;
      tkfs_pkg::C_NO_RANK:  taken = !status_i.rank;
      tkfs_pkg::C_POS_ZERO: taken = status_i.pos_zero;
      tkfs_pkg::C_RANK:     taken = status_i.rank;
      tkfs_pkg::C_NOT_LAST: taken = !status_i.is_last;
      tkfs_pkg::C_EMIT_END: taken = status_i.emit_end;
      tkfs_pkg::C_OUT_BUSY: taken = status_i.out_busy;
      default:              taken = 1'b0;
    endcase
  end

  assign pc_d = taken ? ctrl.jmp : ctrl.nxt;

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tkfs_pkg::ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[hdl/tkfs_dp.sv]
module tkfs_dp #(
  parameter int MAX_KEEP = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tkfs_pkg::ctrl_t               ctrl_i,
  output tkfs_pkg::status_t             status_o,
  input  logic                          cfg_valid_i,
  input  logic [tkfs_pkg::K_W-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tkfs_pkg::TDATA_W-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tkfs_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast
);

  localparam int CNT_W = $clog2(MAX_KEEP + 1);
  localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CMP_W = (CNT_W > tkfs_pkg::K_W) ? CNT_W : tkfs_pkg::K_W;
  localparam int FW    = tkfs_pkg::FREQ_W;
  localparam int WW    = tkfs_pkg::WORD_W;
  localparam int EW    = tkfs_pkg::ENTRY_W;

  logic [tkfs_pkg::K_W-1:0] k_q;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic [CNT_W-1:0]         pos_q, pos_d;
  logic [CNT_W-1:0]         n_q, n_d;
  logic [FW-1:0]            freq_q;
  logic [WW-1:0]            word_q;
  logic                     last_q;
  logic [EW-1:0]            out_q;
  logic                     out_last_q;
  logic                     out_valid_q;

  logic [CMP_W-1:0] k_ext;
  logic [CNT_W-1:0] eff_k;
  logic [CNT_W-1:0] pos_inc;
  logic [CNT_W-1:0] pos_dec;
  logic [CNT_W-1:0] rd_cnt;
  logic [IDX_W-1:0] rd_addr;
  logic [EW-1:0]    rd_data;
  logic [FW-1:0]    rd_freq;
  logic [WW-1:0]    rd_word;
  logic             rank;
  logic             in_take;
  logic             out_busy;
  logic             out_load;
  logic             ram_we;
  logic [EW-1:0]    ram_wdata;

  // Kept list size in use, clamped to 1..MAX_KEEP
  assign k_ext = CMP_W'(k_q);
  always_comb begin
    if (k_q == '0) begin
      eff_k = CNT_W'(1);
    end else if (k_ext > CMP_W'(MAX_KEEP)) begin
      eff_k = CNT_W'(MAX_KEEP);
    end else begin
      eff_k = CNT_W'(k_ext);
    end
  end

  assign pos_inc = pos_q + CNT_W'(1);
  assign pos_dec = pos_q - CNT_W'(1);

  // Memory read address
  always_comb begin
    case (ctrl_i.rd_sel)
      tkfs_pkg::RD_KM1:   rd_cnt = eff_k - CNT_W'(1);
      tkfs_pkg::RD_POSM1: rd_cnt = pos_dec;
      default:            rd_cnt = pos_q;
    endcase
  end
  assign rd_addr = rd_cnt[IDX_W-1:0];

  assign rd_freq = rd_data[FW-1:0];
  assign rd_word = rd_data[EW-1:FW];

  // Held word outranks the entry just read: higher count, or same count and smaller key
  assign rank = (freq_q > rd_freq) || ((freq_q == rd_freq) && (word_q < rd_word));

  assign s_axis_tready = (ctrl_i.act == tkfs_pkg::ACT_ACCEPT);
  assign in_take       = s_axis_tready && s_axis_tvalid;
  assign out_busy      = out_valid_q && !m_axis_tready;
  assign out_load      = (ctrl_i.act == tkfs_pkg::ACT_EMIT) && !out_busy;

  assign status_o.in_valid = s_axis_tvalid;
  assign status_o.not_full = pos_q < eff_k;
  assign status_o.rank     = rank;
  assign status_o.pos_zero = (pos_q == '0);
  assign status_o.is_last  = last_q;
  assign status_o.emit_end = (pos_q == fill_q);
  assign status_o.out_busy = out_busy;

  // Action decode
  always_comb begin
    fill_d    = fill_q;
    pos_d     = pos_q;
    n_d       = n_q;
    ram_we    = 1'b0;
    ram_wdata = rd_data;
    unique case (ctrl_i.act)
      tkfs_pkg::ACT_ACCEPT: begin
        if (in_take) begin
          pos_d = (fill_q > eff_k) ? eff_k : fill_q;
          n_d   = (fill_q > eff_k) ? eff_k : fill_q;
        end
      end
      tkfs_pkg::ACT_FULL_CMP: begin
        if (rank) begin
          pos_d = eff_k - CNT_W'(1);
          n_d   = eff_k - CNT_W'(1);
        end else begin
          fill_d = pos_q;
        end
      end
      tkfs_pkg::ACT_SHIFT: begin
        if (rank) begin
          ram_we = 1'b1;
          pos_d  = pos_dec;
        end
      end
      tkfs_pkg::ACT_WR_NEW: begin
        ram_we    = 1'b1;
        ram_wdata = {word_q, freq_q};
        fill_d    = n_q + CNT_W'(1);
      end
      tkfs_pkg::ACT_LAST: begin
        pos_d = '0;
      end
      tkfs_pkg::ACT_EMIT_CHK: begin
        if (pos_q == fill_q) begin
          fill_d = '0;
        end
      end
      tkfs_pkg::ACT_EMIT: begin
        if (out_load) begin
          pos_d = pos_inc;
        end
      end
      default: ;
    endcase
  end

  // Kept items, best first
  tkfs_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_KEEP)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= tkfs_pkg::K_W'(16);
      fill_q      <= '0;
      pos_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        k_q <= cfg_data_i;
      end
      fill_q <= fill_d;
      pos_q  <= pos_d;
      n_q    <= n_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Held item and output word
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      freq_q <= s_axis_tdata[FW-1:0];
      word_q <= s_axis_tdata[EW-1:FW];
      last_q <= s_axis_tlast;
    end
    if (out_load) begin
      out_q      <= rd_data;
      out_last_q <= (pos_inc == fill_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tkfs_pkg::TDATA_W'(out_q);
  assign m_axis_tlast  = out_last_q;

  // Fill count never runs past the store
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_KEEP))
    else $error("fill count beyond store depth");

  // Writes stay inside the store
  a_wr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (pos_q < CNT_W'(MAX_KEEP)))
    else $error("store write out of range");

  // End of emission empties the list
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctrl_i.act == tkfs_pkg::ACT_EMIT_CHK) && (pos_q == fill_q)) |=> (fill_q == '0))
    else $error("list not emptied after emission");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

  typedef logic [tkfs_pkg::FREQ_W-1:0] freq_t;
  typedef logic [tkfs_pkg::WORD_W-1:0] key_t;

  // One ranked word as it leaves the block
  typedef struct packed {
    freq_t freq;
    key_t  word;
    logic  last;
  } ranked_t;

  localparam int KEEP_MAX   = 16;
  localparam int SETTLE_CYC = 60;    // long enough for the worst-case insertion at full depth
  localparam int QUIET_MAX  = 4000;

  // Packed words, big-endian and zero padded
  localparam key_t KEY_APPLE  = 64'h6170706C65000000;
  localparam key_t KEY_BANANA = 64'h62616E616E610000;
  localparam key_t KEY_CHERRY = 64'h6368657272790000;
  localparam key_t KEY_ONES   = '1;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [tkfs_pkg::K_W-1:0]            cfg_data_i = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [tkfs_pkg::TDATA_W-1:0]        s_axis_tdata = '0;     // freq[31:0], word_key[95:32]
  logic                                s_axis_tlast = 1'b0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [tkfs_pkg::TDATA_W-1:0]        m_axis_tdata;  // out_freq[31:0], out_word_key[95:32]
  logic                                m_axis_tlast;

  // Predictor state: kept words best first, fill count and k register
  freq_t                    held_freq [KEEP_MAX];
  key_t                     held_word [KEEP_MAX];
  int unsigned              held_cnt = 0;
  logic [tkfs_pkg::K_W-1:0] keep_reg = 5'd16;

  ranked_t ranking_q[$];
  ranked_t head;

  bit bursty = 1'b0;
  int n_fail = 0;
  int n_words = 0;
  int n_ranked = 0;
  int n_sets = 0;
  int quiet_cycles = 0;
  int stall_left = 0;

  top_k_frequency_select_top #(.MAX_KEEP(KEEP_MAX)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit ranks_above(freq_t fa, key_t wa, freq_t fb, key_t wb);
    return (fa > fb) || (fa == fb && wa < wb);
  endfunction

  // k of 0 behaves as 1, anything past the store depth as the depth
  function automatic int unsigned keep_limit();
    int unsigned k;
    k = keep_reg;
    if (k == 0) k = 1;
    if (k > KEEP_MAX) k = KEEP_MAX;
    return k;
  endfunction

  task automatic rank_insert(input freq_t f, input key_t w);
    int unsigned k, n, p;
    k = keep_limit();
    n = (held_cnt > k) ? k : held_cnt;
    if (n >= k) begin
      // full list: only a strictly better word evicts the weakest
      if (!ranks_above(f, w, held_freq[k-1], held_word[k-1])) begin
        held_cnt = n;
        return;
      end
      n = k - 1;
    end
    p = n;
    while (p > 0 && ranks_above(f, w, held_freq[p-1], held_word[p-1])) begin
      held_freq[p] = held_freq[p-1];
      held_word[p] = held_word[p-1];
      p--;
    end
    held_freq[p] = f;
    held_word[p] = w;
    held_cnt = n + 1;
  endtask

  // Accepted input word: update the list, queue the ranking on last
  task automatic predict_ranking(input freq_t f, input key_t w, input logic l);
    ranked_t r;
    rank_insert(f, w);
    if (l) begin
      for (int unsigned i = 0; i < held_cnt; i++) begin
        r.freq = held_freq[i];
        r.word = held_word[i];
        r.last = (i + 1 == held_cnt);
        ranking_q.push_back(r);
      end
      held_cnt = 0;
      n_sets++;
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // Send one word, with an optional random gap ahead of it
  task automatic send_word(input freq_t f, input key_t w, input logic l);
    int gap;
    if (bursty && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {w, f};
    s_axis_tlast  = l;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_ranking(f, w, l);
    n_words++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every queued ranking word is back
  task automatic drain_rankings();
    s_axis_tvalid = 1'b0;
    while (ranking_q.size() != 0) @(negedge clk_i);
  endtask

  // Write k only with the block idle: drained, then let a pending insertion finish
  task automatic set_keep(input logic [tkfs_pkg::K_W-1:0] k);
    drain_rankings();
    repeat (SETTLE_CYC) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = k;
    do @(posedge clk_i); while (!cfg_ready_o);
    keep_reg = k;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Output stalls in random bursts, started only in bursty mode
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (bursty && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_ranked++;
      if (ranking_q.size() == 0) begin
        $error("unexpected ranking word freq=%0h word=%0h", m_axis_tdata[31:0],
               m_axis_tdata[95:32]);
        n_fail++;
      end else begin
        head = ranking_q.pop_front();
        if (m_axis_tdata[31:0] !== head.freq) begin
          $error("out_freq expected %0h actual %0h", head.freq, m_axis_tdata[31:0]);
          n_fail++;
        end
        if (m_axis_tdata[95:32] !== head.word) begin
          $error("out_word_key expected %0h actual %0h", head.word, m_axis_tdata[95:32]);
          n_fail++;
        end
        if (m_axis_tlast !== head.last) begin
          $error("out_last expected %0b actual %0b", head.last, m_axis_tlast);
          n_fail++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic freq_t rand_freq();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return freq_t'($urandom_range(0, 7));
      default: return freq_t'($urandom);
    endcase
  endfunction

  // Random keys, or short words from a small alphabet so ties are common
  function automatic key_t rand_word();
    if ($urandom_range(0, 1) == 0) begin
      return {$urandom, $urandom};
    end
    return {8'(8'h61 + $urandom_range(0, 2)), 8'(8'h61 + $urandom_range(0, 2)), 48'h0};
  endfunction

  function automatic logic [tkfs_pkg::K_W-1:0] rand_keep();
    case ($urandom_range(0, 7))
      0:       return 5'd1;
      1:       return 5'd16;
      2:       return ($urandom_range(0, 3) == 0) ? 5'd0
                                                  : tkfs_pkg::K_W'($urandom_range(17, 31));
      default: return tkfs_pkg::K_W'($urandom_range(1, 16));
    endcase
  endfunction

  // Reset value of k, fewer words than k, extremes of every field
  task automatic test_default_keep();
    send_word('1, KEY_ONES, 1'b0);
    send_word('0, '0, 1'b0);
    send_word(32'd5, KEY_APPLE, 1'b0);
    send_word(32'd5, KEY_APPLE, 1'b0);
    send_word(32'd5, KEY_BANANA, 1'b0);
    send_word('1, '0, 1'b1);
    send_word('0, '0, 1'b1);
  endtask

  // Identical words kept side by side, rejects of equal and weaker words
  task automatic test_ties_and_rejects();
    set_keep(5'd2);
    send_word(32'd7, KEY_APPLE, 1'b0);
    send_word(32'd7, KEY_APPLE, 1'b0);
    send_word(32'd7, KEY_APPLE, 1'b0);
    send_word(32'd6, KEY_CHERRY, 1'b0);
    send_word(32'd7, KEY_BANANA, 1'b0);
    send_word(32'd8, KEY_CHERRY, 1'b1);
    set_keep(5'd1);
    send_word(32'd3, KEY_BANANA, 1'b0);
    send_word(32'd3, KEY_APPLE, 1'b1);
  endtask

  // k lowered while a set is open: the list gets cut before the next word
  task automatic test_keep_cut_mid_set();
    set_keep(5'd4);
    send_word(32'd40, KEY_APPLE, 1'b0);
    send_word(32'd10, KEY_BANANA, 1'b0);
    send_word(32'd30, KEY_CHERRY, 1'b0);
    send_word(32'd20, KEY_APPLE, 1'b0);
    set_keep(5'd2);
    send_word(32'd1, KEY_BANANA, 1'b1);
  endtask

  // k of zero and k past the store depth
  task automatic test_keep_out_of_range();
    set_keep(5'd0);
    send_word(32'd9, KEY_APPLE, 1'b0);
    send_word(32'd10, KEY_BANANA, 1'b1);
    set_keep(5'd31);
    send_word(32'd2, KEY_CHERRY, 1'b0);
    send_word(32'd2, KEY_APPLE, 1'b0);
    send_word('1, KEY_ONES, 1'b1);
  endtask

  // Random sets under changing k, with output stalls and input gaps
  task automatic test_random_sets();
    int sent;
    int set_len;
    int cut_at;
    sent = 0;
    while (sent < 130) begin
      if ($urandom_range(0, 2) == 0) set_keep(rand_keep());
      bursty  = ($urandom_range(0, 3) != 0);
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24)
                                             : $urandom_range(1, keep_limit() + 6);
      cut_at  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, set_len) : -1;
      for (int i = 0; i < set_len; i++) begin
        if (i == cut_at) set_keep(rand_keep());
        send_word(rand_freq(), rand_word(), i == set_len - 1);
      end
      sent += set_len;
    end
  endtask

  // Back-to-back sets at full rate, no stalls on either side
  task automatic test_full_rate();
    bursty = 1'b0;
    set_keep(5'd16);
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < 5; i++) send_word(rand_freq(), rand_word(), i == 4);
    end
    s_axis_tvalid = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    bursty = 1'b1;
    test_default_keep();
    test_ties_and_rejects();
    test_keep_cut_mid_set();
    test_keep_out_of_range();
    test_random_sets();
    test_full_rate();

    drain_rankings();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (ranking_q.size() != 0) begin
      $error("%0d ranking words never arrived", ranking_q.size());
      n_fail++;
    end

    $display("Sent %0d input words in %0d sets; checked %0d ranked words.",
             n_words, n_sets, n_ranked);
    $display("k covered 0, 1, 2..16 and values past 16, incl. a cut inside an open set.");
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tkfs_pkg.sv
hdl/tkfs_ram.sv
hdl/tkfs_seq.sv
hdl/tkfs_dp.sv
hdl/top_k_frequency_select_top.sv
verif/tb.sv
